// ----- hdl/udrb_pkg.sv -----
// ----------------------------------------------------------------------------
// udrb_pkg
// Shared constants and codes for the dual ring buffer serial engine.
// ----------------------------------------------------------------------------
package udrb_pkg;

    localparam int SEND_DEPTH = 1024;
    localparam int RECV_DEPTH = 2048;
    localparam int READ_BURST = 64;

    localparam int SEND_AW = $clog2(SEND_DEPTH);
    localparam int RECV_AW = $clog2(RECV_DEPTH);

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int BLEN_W     = 10;
    localparam int CNT_W      = 7;
    localparam int RX_LVL_W   = 11;
    localparam int TX_SPACE_W = 10;

    // comparator operand width: wide enough for every value it sees
    localparam int CMP_W0 = (SEND_AW > RECV_AW) ? SEND_AW : RECV_AW;
    localparam int CMP_W1 = (CMP_W0 > BLEN_W) ? CMP_W0 : BLEN_W;
    localparam int CMP_W  = (CMP_W1 > CNT_W) ? CMP_W1 : CNT_W;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        OP_TX_BYTE    = 2'd0,
        OP_LINE_READY = 2'd1,
        OP_RX_BYTE    = 2'd2,
        OP_READ_REQ   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TX_REJECT = 2'd1,
        STAT_RX_FULL   = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CALC   = 8'b0000_0010,
        ST_CLAMP  = 8'b0000_0100,
        ST_SFETCH = 8'b0000_1000,
        ST_SDATA  = 8'b0001_0000,
        ST_RFETCH = 8'b0010_0000,
        ST_RDATA  = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

endpackage

// ----- hdl/udrb_ram.sv -----
// ----------------------------------------------------------------------------
// udrb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module udrb_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/uart_dual_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer
// Serial engine with a transmit ring and a receive ring, one item at a time.
// ----------------------------------------------------------------------------
// The block takes one item, works on it under a small sequencer and accepts
// the next item only after its last result transfer. Transmit bytes, received
// bytes and line-ready events with nothing queued pass accept, compute and
// result. An item that pops the transmit ring also passes a fetch and a data
// capture, as the ring memory has a registered read port. A read request with
// nothing to return passes accept, compute, clamp and result; else each byte
// is a memory fetch, data capture and result transfer (one comparator is
// shared for the admission check and both clamps). Stalls on m_tready add
// cycles. The ring memories need no clearing after reset.
module uart_dual_ring_buffer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_byte[7:0], block_first[8], block_length[18:9], line_empty[19],
    // read_max[26:20], zero fill above
    input  logic [udrb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,   // block_last
    input  logic [1:0]                     s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // send_valid[0], send_byte[8:1], read_valid[9], read_byte[17:10],
    // read_count[24:18], receive_level[35:25], transmit_space[45:36], zero fill
    output logic [udrb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,   // last
    output logic [1:0]                     m_tuser    // status
);

    import udrb_pkg::*;

    state_t state_reg, state_next;

    // latched item
    opcode_t           op_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              first_reg;
    logic              lastb_reg;
    logic [BLEN_W-1:0] blen_reg;
    logic              lempty_reg;
    logic [CNT_W-1:0]  rmax_reg;

    // ring state
    logic [SEND_AW-1:0] send_head_reg, send_head_next;
    logic [SEND_AW-1:0] send_tail_reg, send_tail_next;
    logic [SEND_AW-1:0] send_level_reg, send_level_next;
    logic [RECV_AW-1:0] recv_head_reg, recv_head_next;
    logic [RECV_AW-1:0] recv_tail_reg, recv_tail_next;
    logic [RECV_AW-1:0] recv_level_reg, recv_level_next;
    logic               drop_reg, drop_next;

    logic [CMP_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rem_reg, rem_next;

    // result register
    status_t           out_status_reg, out_status_next;
    logic              out_sv_reg, out_sv_next;
    logic [BYTE_W-1:0] out_sb_reg, out_sb_next;
    logic              out_rv_reg, out_rv_next;
    logic [BYTE_W-1:0] out_rb_reg, out_rb_next;
    logic [CNT_W-1:0]  out_rc_reg, out_rc_next;
    logic              out_last_reg, out_last_next;

    // shared comparator
    logic [CMP_W-1:0] cmp_a, cmp_b;
    logic             cmp_lt;

    logic [SEND_AW-1:0] send_space;
    logic               send_we, send_re, recv_we, recv_re;
    logic [BYTE_W-1:0]  send_rdata, recv_rdata;
    logic               drop_now, tx_write;
    logic [CMP_W-1:0]   clamp_cnt;
    logic               s_xfer, m_xfer;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = (state_reg == ST_OUT);
    assign s_xfer     = s_tvalid && s_tready;
    assign m_xfer     = m_tvalid && m_tready;
    assign send_space = SEND_AW'(SEND_DEPTH - 1) - send_level_reg;

    always_comb begin
        cmp_a = CMP_W'(0);
        cmp_b = CMP_W'(0);
        if (state_reg == ST_CLAMP) begin
            cmp_a = CMP_W'(READ_BURST);
            cmp_b = cnt_reg;
        end else if (op_reg == OP_READ_REQ) begin
            cmp_a = CMP_W'(rmax_reg);
            cmp_b = CMP_W'(recv_level_reg);
        end else begin
            cmp_a = CMP_W'(send_space);
            cmp_b = CMP_W'(blen_reg);
        end
    end

    assign cmp_lt    = cmp_a < cmp_b;
    assign clamp_cnt = cmp_lt ? CMP_W'(READ_BURST) : cnt_reg;

    // admission is checked against the space before this byte is written
    assign drop_now = first_reg ? cmp_lt : drop_reg;
    assign tx_write = !drop_now && (send_space != SEND_AW'(0));

    always_comb begin
        state_next      = state_reg;
        send_head_next  = send_head_reg;
        send_tail_next  = send_tail_reg;
        send_level_next = send_level_reg;
        recv_head_next  = recv_head_reg;
        recv_tail_next  = recv_tail_reg;
        recv_level_next = recv_level_reg;
        drop_next       = drop_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        out_status_next = out_status_reg;
        out_sv_next     = out_sv_reg;
        out_sb_next     = out_sb_reg;
        out_rv_next     = out_rv_reg;
        out_rb_next     = out_rb_reg;
        out_rc_next     = out_rc_reg;
        out_last_next   = out_last_reg;
        send_we         = 1'b0;
        send_re         = 1'b0;
        recv_we         = 1'b0;
        recv_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                out_status_next = STAT_OK;
                out_sv_next     = 1'b0;
                out_sb_next     = '0;
                out_rv_next     = 1'b0;
                out_rb_next     = '0;
                out_rc_next     = '0;
                out_last_next   = 1'b1;
                state_next      = ST_OUT;
                unique case (op_reg)
                    OP_TX_BYTE: begin
                        send_we = tx_write;
                        if (tx_write) begin
                            send_head_next  = send_head_reg + SEND_AW'(1);
                            send_level_next = send_level_reg + SEND_AW'(1);
                        end else begin
                            out_status_next = STAT_TX_REJECT;
                        end
                        if (lastb_reg) begin
                            drop_next = 1'b0;
                            if (!drop_now && lempty_reg &&
                                (tx_write || send_level_reg != SEND_AW'(0))) begin
                                state_next = ST_SFETCH;
                            end
                        end else begin
                            drop_next = drop_now;
                        end
                    end
                    OP_LINE_READY: begin
                        if (send_level_reg != SEND_AW'(0)) begin
                            state_next = ST_SFETCH;
                        end else begin
                            out_status_next = STAT_EMPTY;
                        end
                    end
                    OP_RX_BYTE: begin
                        if (recv_level_reg == RECV_AW'(RECV_DEPTH - 1)) begin
                            out_status_next = STAT_RX_FULL;
                        end else begin
                            recv_we         = 1'b1;
                            recv_head_next  = recv_head_reg + RECV_AW'(1);
                            recv_level_next = recv_level_reg + RECV_AW'(1);
                        end
                    end
                    OP_READ_REQ: begin
                        cnt_next   = cmp_lt ? CMP_W'(rmax_reg) : CMP_W'(recv_level_reg);
                        state_next = ST_CLAMP;
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_CLAMP: begin
                if (clamp_cnt == CMP_W'(0)) begin
                    out_status_next = STAT_EMPTY;
                    state_next      = ST_OUT;
                end else begin
                    // level is reported after the whole burst on every byte
                    recv_level_next = recv_level_reg - RECV_AW'(clamp_cnt);
                    rem_next        = CNT_W'(clamp_cnt);
                    out_rc_next     = CNT_W'(clamp_cnt);
                    state_next      = ST_RFETCH;
                end
            end
            ST_SFETCH: begin
                send_re         = 1'b1;
                send_tail_next  = send_tail_reg + SEND_AW'(1);
                send_level_next = send_level_reg - SEND_AW'(1);
                state_next      = ST_SDATA;
            end
            ST_SDATA: begin
                out_sv_next = 1'b1;
                out_sb_next = send_rdata;
                state_next  = ST_OUT;
            end
            ST_RFETCH: begin
                recv_re        = 1'b1;
                recv_tail_next = recv_tail_reg + RECV_AW'(1);
                rem_next       = rem_reg - CNT_W'(1);
                state_next     = ST_RDATA;
            end
            ST_RDATA: begin
                out_status_next = STAT_OK;
                out_rv_next     = 1'b1;
                out_rb_next     = recv_rdata;
                out_last_next   = (rem_reg == CNT_W'(0));
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (m_xfer) begin
                    state_next = (rem_reg != CNT_W'(0)) ? ST_RFETCH : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            send_head_reg  <= '0;
            send_tail_reg  <= '0;
            send_level_reg <= '0;
            recv_head_reg  <= '0;
            recv_tail_reg  <= '0;
            recv_level_reg <= '0;
            drop_reg       <= 1'b0;
            rem_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            send_head_reg  <= send_head_next;
            send_tail_reg  <= send_tail_next;
            send_level_reg <= send_level_next;
            recv_head_reg  <= recv_head_next;
            recv_tail_reg  <= recv_tail_next;
            recv_level_reg <= recv_level_next;
            drop_reg       <= drop_next;
            rem_reg        <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg     <= opcode_t'(s_tuser);
            data_reg   <= s_tdata[7:0];
            first_reg  <= s_tdata[8];
            blen_reg   <= s_tdata[18:9];
            lempty_reg <= s_tdata[19];
            rmax_reg   <= s_tdata[26:20];
            lastb_reg  <= s_tlast;
        end
        cnt_reg        <= cnt_next;
        out_status_reg <= out_status_next;
        out_sv_reg     <= out_sv_next;
        out_sb_reg     <= out_sb_next;
        out_rv_reg     <= out_rv_next;
        out_rb_reg     <= out_rb_next;
        out_rc_reg     <= out_rc_next;
        out_last_reg   <= out_last_next;
    end

    // depths are powers of two, so the pointers wrap on their own
    udrb_ram #(
        .DEPTH (SEND_DEPTH),
        .WIDTH (BYTE_W)
    ) u_send_ram (
        .aclk  (aclk),
        .we    (send_we),
        .waddr (send_head_reg),
        .wdata (data_reg),
        .re    (send_re),
        .raddr (send_tail_reg),
        .rdata (send_rdata)
    );

    udrb_ram #(
        .DEPTH (RECV_DEPTH),
        .WIDTH (BYTE_W)
    ) u_recv_ram (
        .aclk  (aclk),
        .we    (recv_we),
        .waddr (recv_head_reg),
        .wdata (data_reg),
        .re    (recv_re),
        .raddr (recv_tail_reg),
        .rdata (recv_rdata)
    );

    assign m_tdata = {
        2'b00,
        TX_SPACE_W'(send_space),
        RX_LVL_W'(recv_level_reg),
        out_rc_reg,
        out_rb_reg,
        out_rv_reg,
        out_sb_reg,
        out_sv_reg
    };
    assign m_tlast = out_last_reg;
    assign m_tuser = out_status_reg;

    // ------------------------------------------------------------------------
    // assertions

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result sides active together");

    a_accept_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == ST_CALC))
        else $error("accepted item not processed");

    a_send_level: assert property (@(posedge aclk) disable iff (!aresetn)
        send_level_reg == SEND_AW'(send_head_reg - send_tail_reg))
        else $error("transmit level out of step with pointers");

    a_rx_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        recv_we |-> (recv_level_reg != RECV_AW'(RECV_DEPTH - 1)))
        else $error("write into full receive ring");

    a_burst_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && out_rv_reg && !out_last_reg) |=> (state_reg == ST_RFETCH))
        else $error("read burst ended before its last byte");

endmodule
